FILE: rtl/core/cals_pkg.sv
// ----------------------------------------------------------------------------
// cals_pkg
// Shared types and constants for the CAF sample-byte steganography block.
// ----------------------------------------------------------------------------
package cals_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_DESC   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_EDIT   = 3'd5;
    localparam logic [2:0] PH_SAMPLE = 3'd6;

    // Four-character tags, big-endian
    localparam logic [31:0] TAG_CAFF = 32'h6361_6666;
    localparam logic [31:0] TAG_DESC = 32'h6465_7363;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Phase lengths minus one, as seen by the phase counter, and the file tag length
    localparam logic [5:0] HDR_LAST  = 6'd7;
    localparam logic [5:0] TAG_LAST  = 6'd3;
    localparam logic [5:0] SIZE_LAST = 6'd7;
    localparam logic [5:0] DESC_LAST = 6'd31;
    localparam logic [5:0] EDIT_LAST = 6'd3;
    localparam logic [5:0] HDR_TAG_LEN = 6'd4;

    // Default sample width of 16 bits, as bytes per sample
    localparam logic [3:0] BPS_RESET = 4'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       carrier_slot;
        logic       extracted_bit;
        logic       in_samples;
        logic       header_mismatch;
    } t_result;

    // Expected byte of the file tag at position idx
    function automatic logic [7:0] caff_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = TAG_CAFF[31:24];
            2'd1:    v = TAG_CAFF[23:16];
            2'd2:    v = TAG_CAFF[15:8];
            default: v = TAG_CAFF[7:0];
        endcase
        return v;
    endfunction

    // Bytes per sample from a sample width in bits, clamped to 1..8
    function automatic logic [3:0] bytes_per_sample(input logic [7:0] bits);
        logic [4:0] n;
        logic [3:0] r;
        n = bits[7:3];
        if (n == 5'd0) begin
            r = 4'd1;
        end else if (n > 5'd8) begin
            r = 4'd8;
        end else begin
            r = n[3:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/cals_in_reg.sv
// ----------------------------------------------------------------------------
// cals_in_reg
// Input register: captures one byte transfer and holds it until consumed.
// ----------------------------------------------------------------------------
module cals_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_message_bit,
    input  logic       i_advance,
    output logic       o_held_valid,
    output logic [7:0] o_held_byte,
    output logic       o_held_mbit
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_mbit;
    logic       take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: load on every transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_in_byte;
            r_mbit <= i_message_bit;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_byte  = r_byte;
    assign o_held_mbit  = r_mbit;

endmodule

FILE: rtl/core/cals_parser.sv
// ----------------------------------------------------------------------------
// cals_parser
// CAF chunk parser state and per-byte result logic.
// ----------------------------------------------------------------------------
module cals_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_mbit,
    output cals_pkg::t_result o_result
);

    import cals_pkg::*;

    logic        r_embed;
    logic [2:0]  r_phase,  n_phase;
    logic [5:0]  r_count,  n_count;
    logic [31:0] r_tag,    n_tag;
    logic [63:0] r_len,    n_len;
    logic [3:0]  r_bps,    n_bps;
    logic [2:0]  r_bis,    n_bis;
    logic        r_bad,    n_bad;
    logic [3:0]  bis_inc;
    t_result     res;

    assign bis_inc = {1'b0, r_bis} + 4'd1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count + 6'd1;
        n_tag   = r_tag;
        n_len   = r_len;
        n_bps   = r_bps;
        n_bis   = r_bis;
        n_bad   = r_bad;

        res.out_byte      = i_byte;
        res.carrier_slot  = 1'b0;
        res.extracted_bit = 1'b0;
        res.in_samples    = 1'b0;

        case (r_phase)
            PH_TAG: begin
                n_tag = {r_tag[23:0], i_byte};
                if (r_count == TAG_LAST) begin
                    n_len   = '0;
                    n_phase = PH_SIZE;
                    n_count = '0;
                end
            end
            PH_SIZE: begin
                n_len = {r_len[55:0], i_byte};
                if (r_count == SIZE_LAST) begin
                    n_count = '0;
                    if (r_tag == TAG_DESC) begin
                        n_phase = PH_DESC;
                    end else if (r_tag == TAG_DATA) begin
                        n_phase = PH_EDIT;
                    end else if (n_len == 64'd0) begin
                        n_phase = PH_TAG;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_DESC: begin
                if (r_count == DESC_LAST) begin
                    n_bps   = bytes_per_sample(i_byte);
                    n_phase = PH_TAG;
                    n_count = '0;
                end
            end
            PH_SKIP: begin
                // Count the remaining body bytes down; size is never zero here
                n_count = '0;
                if (r_len == 64'd1) begin
                    n_phase = PH_TAG;
                end else begin
                    n_len = r_len - 64'd1;
                end
            end
            PH_EDIT: begin
                if (r_count == EDIT_LAST) begin
                    n_bis   = '0;
                    n_phase = PH_SAMPLE;
                    n_count = '0;
                end
            end
            PH_SAMPLE: begin
                n_count = '0;
                res.in_samples = 1'b1;
                if (r_bis == 3'd1) begin
                    res.carrier_slot  = 1'b1;
                    res.extracted_bit = i_byte[0];
                    if (r_embed) begin
                        res.out_byte = {i_byte[7:1], i_mbit};
                    end
                end
                if (bis_inc >= r_bps) begin
                    n_bis = '0;
                end else begin
                    n_bis = bis_inc[2:0];
                end
            end
            default: begin
                n_phase = PH_HEADER;
                if (r_count < HDR_TAG_LEN && caff_byte(r_count[1:0]) != i_byte) begin
                    n_bad = 1'b1;
                end
                if (r_count == HDR_LAST) begin
                    n_tag   = '0;
                    n_phase = PH_TAG;
                    n_count = '0;
                end
            end
        endcase

        res.header_mismatch = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_embed <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_embed <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_tag   <= '0;
            r_len   <= '0;
            r_bps   <= BPS_RESET;
            r_bis   <= '0;
            r_bad   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_bps   <= n_bps;
            r_bis   <= n_bis;
            r_bad   <= n_bad;
        end
    end

    assign o_result = res;

endmodule

FILE: rtl/core/cals_out_reg.sv
// ----------------------------------------------------------------------------
// cals_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module cals_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  cals_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output cals_pkg::t_result o_result
);

    import cals_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result leaves this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/core/caf_audio_lsb_stego.sv
// ----------------------------------------------------------------------------
// caf_audio_lsb_stego
// Byte-serial CAF parser: hides or recovers one bit per multi-byte audio sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one file byte per transfer with
//   the message bit to hide. Output channel (o_valid / i_stall) returns one
//   result per input byte, in order: the byte (LSB = message bit on embed
//   carriers), carrier flag, recovered bit, sample-data flag and the sticky
//   header mismatch flag. i_cfg_wr_en / i_cfg_wr_data set embed mode (1) or
//   extract mode (0); write it only while no byte is in flight.
// Path: each byte is registered in the input register, then passes the parse
//   logic into the result register, which drives the output channel.
// Throughput: one byte per cycle, sustained, while the receiver does not
//   stall; the parser state updates as each byte is committed, with the
//   chunk skip counted down in one 64-bit decrementer.
// Reset: synchronous, active low. Empties both registers, returns the
//   parser to the file header, sets the sample width to 16 bits and clears
//   embed mode.
// Stall: while the receiver stalls, the result register holds its transfer
//   and the input register keeps one more byte; then o_stall rises.
// ----------------------------------------------------------------------------
module caf_audio_lsb_stego (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    // Input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_message_bit,
    // Output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_carrier_slot,
    output logic       o_extracted_bit,
    output logic       o_in_samples,
    output logic       o_header_mismatch
);

    import cals_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_mbit;
    logic       out_ready;
    logic       advance;
    t_result    parse_res;
    t_result    out_res;

    // Move the held byte into the result register whenever it has room
    assign advance = held_valid && out_ready;

    cals_in_reg u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_message_bit (i_message_bit),
        .i_advance     (advance),
        .o_held_valid  (held_valid),
        .o_held_byte   (held_byte),
        .o_held_mbit   (held_mbit)
    );

    // Parser state advances only on the cycle its byte is committed
    cals_parser u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (advance),
        .i_byte        (held_byte),
        .i_mbit        (held_mbit),
        .o_result      (parse_res)
    );

    cals_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (held_valid),
        .i_result    (parse_res),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (out_res)
    );

    assign o_out_byte        = out_res.out_byte;
    assign o_carrier_slot    = out_res.carrier_slot;
    assign o_extracted_bit   = out_res.extracted_bit;
    assign o_in_samples      = out_res.in_samples;
    assign o_header_mismatch = out_res.header_mismatch;

endmodule

FILE: rtl/core/cals_checker.sv
// ----------------------------------------------------------------------------
// cals_checker
// Port-level checks for caf_audio_lsb_stego, attached by bind.
// ----------------------------------------------------------------------------
module cals_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic [7:0] o_out_byte,
    input  logic       o_carrier_slot,
    input  logic       o_extracted_bit,
    input  logic       o_in_samples,
    input  logic       o_header_mismatch
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte))
        else $error("stalled result changed");

    // Carrier bytes only occur inside sample data
    a_carrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_carrier_slot |-> o_in_samples)
        else $error("carrier outside sample data");

    // Recovered bit is zero away from a carrier byte
    a_xbit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_carrier_slot |-> !o_extracted_bit)
        else $error("extracted bit set off carrier");

    // Header mismatch stays set on a result that directly follows a taken one
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_header_mismatch |=> !o_valid || o_header_mismatch)
        else $error("header mismatch cleared");

    // Nothing valid straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind caf_audio_lsb_stego cals_checker u_cals_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_out_byte        (o_out_byte),
    .o_carrier_slot    (o_carrier_slot),
    .o_extracted_bit   (o_extracted_bit),
    .o_in_samples      (o_in_samples),
    .o_header_mismatch (o_header_mismatch)
);
